// ----- sv/unsigned_divide_64bit_core_defines.svh -----
// Assertion macros used by the checker of the unsigned divider.
`ifndef UNSIGNED_DIVIDE_64BIT_CORE_DEFINES_SVH
`define UNSIGNED_DIVIDE_64BIT_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UDIV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("udiv assertion failed: same cycle");

// The consequent must hold in the cycle after the antecedent.
`define UDIV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("udiv assertion failed: next cycle");

`endif

// ----- sv/udiv_pkg.sv -----
// Shared constants and types of the unsigned divider.
package udiv_pkg;

    localparam int unsigned WORD_BITS = 64;
    localparam int unsigned CNT_BITS  = $clog2(WORD_BITS);

    typedef struct packed {
        logic load;
        logic step;
    } t_cell_ctl;

endpackage

// ----- sv/udiv_cell.sv -----
// One bit slice of the divider: remainder, quotient and divisor bits with a borrow stage.
module udiv_cell (
    input  logic                i_clk,
    input  udiv_pkg::t_cell_ctl i_ctl,
    input  logic                i_sub,
    input  logic                i_rem_in,
    input  logic                i_quo_in,
    input  logic                i_borrow,
    input  logic                i_dividend_bit,
    input  logic                i_divisor_bit,
    output logic                o_rem,
    output logic                o_quo,
    output logic                o_borrow
);

    logic r_rem;
    logic r_quo;
    logic r_den;
    logic n_rem;
    logic n_quo;
    logic n_den;
    logic w_diff;

    assign w_diff   = i_rem_in ^ r_den ^ i_borrow;
    assign o_borrow = (~i_rem_in & r_den) | (~(i_rem_in ^ r_den) & i_borrow);

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        n_den = r_den;
        if (i_ctl.load) begin
            n_rem = 1'b0;
            n_quo = i_dividend_bit;
            n_den = i_divisor_bit;
        end else if (i_ctl.step) begin
            n_rem = i_sub ? w_diff : i_rem_in;
            n_quo = i_quo_in;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

// ----- sv/udiv_ctrl.sv -----
// Sequencer of the divider: accepts a transaction, counts the steps and presents the result.
module udiv_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_stall,
    input  logic                i_divisor_zero,
    output udiv_pkg::t_cell_ctl o_ctl,
    output logic                o_valid,
    output logic                o_stall,
    output logic                o_divide_by_zero
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                   r_state;
    logic [1:0]                   n_state;
    logic [udiv_pkg::CNT_BITS-1:0] r_count;
    logic [udiv_pkg::CNT_BITS-1:0] n_count;
    logic                         r_dbz;
    logic                         n_dbz;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_dbz      = r_dbz;
        o_ctl.load = 1'b0;
        o_ctl.step = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    n_dbz      = i_divisor_zero;
                    n_count    = udiv_pkg::CNT_BITS'(udiv_pkg::WORD_BITS - 1);
                    n_state    = ST_BUSY;
                end
            end
            ST_BUSY: begin
                o_ctl.step = 1'b1;
                if (r_count == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            ST_DONE: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_count <= n_count;
        r_dbz   <= n_dbz;
    end

    assign o_valid          = (r_state == ST_DONE);
    assign o_stall          = (r_state != ST_IDLE);
    assign o_divide_by_zero = r_dbz;

endmodule

// ----- sv/unsigned_divide_64bit_core.sv -----
// Top level of the 64-bit unsigned restoring divider built from a row of bit cells.
// A transaction is loaded into the cells and then takes 64 shift-and-subtract steps,
// one quotient bit per cycle; its result is held until the receiver takes it.
// A new transaction is accepted only after the previous result has been handed off.
// Reset returns the sequencer to idle; the cells are reloaded by every transaction.
module unsigned_divide_64bit_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [udiv_pkg::WORD_BITS-1:0] i_dividend,
    input  logic [udiv_pkg::WORD_BITS-1:0] i_divisor,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [udiv_pkg::WORD_BITS-1:0] o_quotient,
    output logic [udiv_pkg::WORD_BITS-1:0] o_remainder,
    output logic                           o_divide_by_zero
);

    localparam int unsigned W = udiv_pkg::WORD_BITS;

    udiv_pkg::t_cell_ctl w_ctl;
    logic [W-1:0]        w_rem;
    logic [W-1:0]        w_quo;
    logic [W:0]          w_borrow;
    logic                w_sub;

    udiv_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_stall          (i_stall),
        .i_divisor_zero   (i_divisor == '0),
        .o_ctl            (w_ctl),
        .o_valid          (o_valid),
        .o_stall          (o_stall),
        .o_divide_by_zero (o_divide_by_zero)
    );

    assign w_borrow[0] = 1'b0;
    assign w_sub       = w_rem[W-1] | ~w_borrow[W];

    for (genvar g = 0; g < W; g++) begin : g_cell
        udiv_cell u_cell (
            .i_clk          (i_clk),
            .i_ctl          (w_ctl),
            .i_sub          (w_sub),
            .i_rem_in       ((g == 0) ? w_quo[W-1] : w_rem[(g == 0) ? 0 : g - 1]),
            .i_quo_in       ((g == 0) ? w_sub : w_quo[(g == 0) ? 0 : g - 1]),
            .i_borrow       (w_borrow[g]),
            .i_dividend_bit (i_dividend[g]),
            .i_divisor_bit  (i_divisor[g]),
            .o_rem          (w_rem[g]),
            .o_quo          (w_quo[g]),
            .o_borrow       (w_borrow[g+1])
        );
    end

    assign o_quotient  = w_quo;
    assign o_remainder = w_rem;

endmodule

// ----- sv/udiv_checker.sv -----
// Port-level checker of the unsigned divider and its bind to the top level.
`include "unsigned_divide_64bit_core_defines.svh"

module udiv_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_stall,
    input logic [udiv_pkg::WORD_BITS-1:0] i_dividend,
    input logic [udiv_pkg::WORD_BITS-1:0] i_divisor,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [udiv_pkg::WORD_BITS-1:0] o_quotient,
    input logic [udiv_pkg::WORD_BITS-1:0] o_remainder,
    input logic                           o_divide_by_zero
);

    logic w_in_fire;

    assign w_in_fire = i_valid && !o_stall && (i_dividend == i_dividend)
        && (i_divisor == i_divisor);

    `UDIV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_quotient) && $stable(o_remainder))

    `UDIV_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, w_in_fire, !o_valid)

    `UDIV_ASSERT_NOW(a_one_at_a_time, i_clk, i_rst_n, o_valid, o_stall)

    `UDIV_ASSERT_NOW(a_zero_divisor_ones, i_clk, i_rst_n, o_valid && o_divide_by_zero,
        ~o_quotient == '0)

endmodule

bind unsigned_divide_64bit_core udiv_checker u_checker (.*);

// ----- bench/tb_unsigned_divide_64bit_core.sv -----
// Self-checking testbench of the 64-bit unsigned divider with corner cases and random traffic.
`timescale 1ns / 100ps

module tb_unsigned_divide_64bit_core;

    localparam int WORD_BITS = udiv_pkg::WORD_BITS;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        t_word quotient;
        t_word remainder;
        logic  divide_by_zero;
    } t_division;

    typedef struct packed {
        t_word dividend;
        t_word divisor;
        logic  known;
        t_word quotient;
        t_word remainder;
        logic  divide_by_zero;
    } t_corner_row;

    localparam t_word ALL_ONES = '1;
    localparam t_word ONE      = t_word'(1);
    localparam t_word TOP_BIT  = t_word'(1) << (WORD_BITS - 1);
    localparam int    NUM_CORNERS  = 20;
    localparam int    NUM_RANDOM   = 2000;
    localparam int    MAX_IDLE     = 5;
    localparam int    DRAIN_CYCLES = 80;

    localparam t_corner_row CORNER_CASES [NUM_CORNERS] = '{
        '{'0,              '0,              1'b1, ALL_ONES,     '0,            1'b1},
        '{ALL_ONES,        '0,              1'b1, ALL_ONES,     ALL_ONES,      1'b1},
        '{TOP_BIT | ONE,   '0,              1'b1, ALL_ONES,     TOP_BIT | ONE, 1'b1},
        '{ONE,             '0,              1'b1, ALL_ONES,     ONE,           1'b1},
        '{'0,              ONE,             1'b1, '0,           '0,            1'b0},
        '{ALL_ONES,        ONE,             1'b1, ALL_ONES,     '0,            1'b0},
        '{ALL_ONES,        ALL_ONES,        1'b1, ONE,          '0,            1'b0},
        '{'0,              ALL_ONES,        1'b1, '0,           '0,            1'b0},
        '{ONE,             ALL_ONES,        1'b1, '0,           ONE,           1'b0},
        '{t_word'(5),      t_word'(7),      1'b1, '0,           t_word'(5),    1'b0},
        '{ALL_ONES,        TOP_BIT,         1'b1, ONE,          TOP_BIT - ONE, 1'b0},
        '{TOP_BIT,         t_word'(2),      1'b1, TOP_BIT >> 1, '0,            1'b0},
        '{TOP_BIT,         TOP_BIT | ONE,   1'b1, '0,           TOP_BIT,       1'b0},
        '{ALL_ONES,        ALL_ONES - ONE,  1'b1, ONE,          ONE,           1'b0},
        '{ALL_ONES - ONE,  ALL_ONES,        1'b1, '0,           ALL_ONES - ONE, 1'b0},
        '{ALL_ONES,        t_word'(2),      1'b0, '0,           '0,            1'b0},
        '{ALL_ONES,        t_word'(3),      1'b0, '0,           '0,            1'b0},
        '{t_word'(100),    t_word'(7),      1'b0, '0,           '0,            1'b0},
        '{64'hDEAD_BEEF_CAFE_F00D, 64'h0000_0000_0001_0003, 1'b0, '0, '0,  1'b0},
        '{64'h5555_5555_5555_5555, 64'h0000_0000_AAAA_AAAB, 1'b0, '0, '0,  1'b0}
    };

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  i_stall = 1'b0;
    t_word i_dividend = '0;
    t_word i_divisor = '0;
    logic  o_stall;
    logic  o_valid;
    t_word o_quotient;
    t_word o_remainder;
    logic  o_divide_by_zero;

    t_division pending_results [$];
    int        mismatch_count = 0;
    bit        sender_quiet = 1'b0;
    bit        receiver_quiet = 1'b0;

    unsigned_divide_64bit_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_dividend       (i_dividend),
        .i_divisor        (i_divisor),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_quotient       (o_quotient),
        .o_remainder      (o_remainder),
        .o_divide_by_zero (o_divide_by_zero)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_division divide_restoring(t_word dividend, t_word divisor);
        t_division result;
        t_word     partial;
        t_word     quotient;
        logic      overflow;
        partial = '0;
        quotient = '0;
        if (divisor == '0) begin
            result.quotient = ALL_ONES;
            result.remainder = dividend;
            result.divide_by_zero = 1'b1;
            return result;
        end
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            overflow = partial[WORD_BITS-1];
            partial = {partial[WORD_BITS-2:0], dividend[i]};
            quotient = {quotient[WORD_BITS-2:0], 1'b0};
            if (overflow || partial >= divisor) begin
                partial = partial - divisor;
                quotient[0] = 1'b1;
            end
        end
        result.quotient = quotient;
        result.remainder = partial;
        result.divide_by_zero = 1'b0;
        return result;
    endfunction

    function automatic t_word random_word(int unsigned bits);
        t_word value;
        value = {$urandom, $urandom};
        if (bits >= WORD_BITS) begin
            return value;
        end
        return value & ((t_word'(1) << bits) - ONE);
    endfunction

    task automatic report_mismatch(string field, t_word got, t_word want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    task automatic send_division(t_word dividend, t_word divisor, t_division result);
        int unsigned gap;
        gap = sender_quiet ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_dividend <= dividend;
        i_divisor <= divisor;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(result);
    endtask

    always @(posedge i_clk) begin
        t_division want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction quotient", o_quotient, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_quotient !== want.quotient) begin
                    report_mismatch("quotient", o_quotient, want.quotient);
                end
                if (o_remainder !== want.remainder) begin
                    report_mismatch("remainder", o_remainder, want.remainder);
                end
                if (o_divide_by_zero !== want.divide_by_zero) begin
                    report_mismatch("divide_by_zero", t_word'(o_divide_by_zero),
                                    t_word'(want.divide_by_zero));
                end
            end
        end
    end

    initial begin
        int unsigned hold;
        int unsigned count;
        count = 0;
        wait (i_rst_n);
        forever begin
            if (count % 150 == 0) begin
                receiver_quiet = ($urandom_range(0, 3) == 0);
            end
            count++;
            hold = receiver_quiet ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold > 0) begin
                i_stall <= 1'b1;
                do @(posedge i_clk); while (!o_valid);
                repeat (hold - 1) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        t_word       dividend;
        t_word       divisor;
        t_division   result;
        int unsigned shape;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (CORNER_CASES[k]) begin
            if (CORNER_CASES[k].known) begin
                result.quotient = CORNER_CASES[k].quotient;
                result.remainder = CORNER_CASES[k].remainder;
                result.divide_by_zero = CORNER_CASES[k].divide_by_zero;
            end else begin
                result = divide_restoring(CORNER_CASES[k].dividend, CORNER_CASES[k].divisor);
            end
            send_division(CORNER_CASES[k].dividend, CORNER_CASES[k].divisor, result);
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % 200 == 0) begin
                sender_quiet = ($urandom_range(0, 3) == 0);
            end
            shape = $urandom_range(0, 9);
            dividend = random_word($urandom_range(0, WORD_BITS));
            divisor = random_word($urandom_range(0, WORD_BITS));
            case (shape)
                0: divisor = '0;
                1: begin
                    dividend = random_word(WORD_BITS);
                    divisor = random_word(WORD_BITS);
                    if (dividend > divisor) begin
                        {dividend, divisor} = {divisor, dividend};
                    end
                end
                2: divisor = dividend;
                3: divisor = t_word'(1) << $urandom_range(0, WORD_BITS - 1);
                4, 5: begin
                    dividend = random_word(WORD_BITS);
                    divisor = random_word(WORD_BITS);
                end
                default: ;
            endcase
            send_division(dividend, divisor, divide_restoring(dividend, divisor));
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #(64'd10_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
